[src/apf_pkg.sv]
// Shared types and constants for the Schroeder allpass filter.
`timescale 1ns / 1ps

package apf_pkg;

  // Default sizing of the delay line and the sample word.
  localparam int MAX_DELAY_DEF   = 4096;
  localparam int SAMPLE_BITS_DEF = 16;

  // Configuration register widths and reset values.
  localparam int GAIN_W      = 15;
  localparam int DELAY_W     = 13;
  localparam int CFG_DATA_W  = 15;
  localparam int CFG_INDEX_W = 1;

  localparam logic [GAIN_W-1:0]  GAIN_RESET  = 15'd22938;
  localparam logic [DELAY_W-1:0] DELAY_RESET = 13'd1024;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_GAIN  = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_DELAY = 1'b1;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL1,
    ST_FB,
    ST_MUL2,
    ST_OUT
  } apf_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_in;   // capture input word and read the delay line
    logic do_mul1;   // multiply gain by the delayed value
    logic do_fb;     // form feedback, write it, advance the pointer
    logic do_mul2;   // multiply gain by the feedback value
    logic load_out;  // form the output word into the output register
  } apf_cmd_t;

endpackage

[src/apf_sample_if.sv]
// Valid/ready channel that carries one signed audio sample per word.
`timescale 1ns / 1ps

interface apf_sample_if #(
  parameter int W = 16
) ();
  logic                valid;
  logic                ready;
  logic signed [W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[src/apf_ctrl.sv]
// Controller state machine that sequences one sample through the datapath.
`timescale 1ns / 1ps

module apf_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              out_ready,
  output logic              out_valid,
  output apf_pkg::apf_cmd_t cmd
);
  import apf_pkg::*;

  apf_state_t state;
  apf_state_t state_next;
  logic       out_free;

  // The output register can take a new word when empty or being drained.
  assign out_free = !out_valid || out_ready;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next-state logic.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_MUL1;
      end
      ST_MUL1: state_next = ST_FB;
      ST_FB:   state_next = ST_MUL2;
      ST_MUL2: state_next = ST_OUT;
      ST_OUT: begin
        if (out_free) state_next = in_valid ? ST_MUL1 : ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Output decode: a new word may enter while the last one is written out.
  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    unique case (state)
      ST_IDLE: in_ready = 1'b1;
      ST_MUL1: cmd.do_mul1 = 1'b1;
      ST_FB:   cmd.do_fb = 1'b1;
      ST_MUL2: cmd.do_mul2 = 1'b1;
      ST_OUT: begin
        in_ready     = out_free;
        cmd.load_out = out_free;
      end
      default: in_ready = 1'b0;
    endcase
    cmd.load_in = in_valid && in_ready;
  end

  // Output valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

[src/apf_datapath.sv]
// Datapath: configuration registers, delay line memory, multiplier and saturating adders.
`timescale 1ns / 1ps

module apf_datapath #(
  parameter int MAX_DELAY   = apf_pkg::MAX_DELAY_DEF,
  parameter int SAMPLE_BITS = apf_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  apf_pkg::apf_cmd_t                   cmd,
  input  logic                                cfg_we,
  input  logic [apf_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [apf_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  input  logic signed [SAMPLE_BITS-1:0]       sample_in,
  output logic signed [SAMPLE_BITS-1:0]       sample_out
);
  import apf_pkg::*;

  localparam int AW  = (MAX_DELAY > 1) ? $clog2(MAX_DELAY) : 1;
  // Width for delay arithmetic: holds the register and sums below twice the depth.
  localparam int DLW = (AW + 1 > DELAY_W) ? AW + 1 : DELAY_W;
  localparam int PW  = SAMPLE_BITS + 17;

  localparam logic [DLW-1:0] MAX_EXT = DLW'(MAX_DELAY);
  localparam logic [DLW-1:0] ONE_EXT = DLW'(1);
  localparam logic [AW-1:0]  WP_LAST = AW'(MAX_DELAY - 1);
  localparam logic signed [PW-1:0] HALF_LSB = PW'(16384);
  localparam logic signed [PW-1:0] S_MAX = PW'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
  localparam logic signed [PW-1:0] S_MIN = -S_MAX - PW'(1);

  // Configuration registers.
  logic [GAIN_W-1:0]  gain_q15;
  logic [DELAY_W-1:0] delay_samples;

  // Delay line and its bookkeeping.
  logic [SAMPLE_BITS-1:0] mem [MAX_DELAY];
  logic [SAMPLE_BITS-1:0] rdata;
  logic                   rd_ok;
  logic [AW-1:0]          wp;
  logic                   wrapped;

  // Pipeline registers.
  logic signed [SAMPLE_BITS-1:0] x_reg;
  logic signed [SAMPLE_BITS-1:0] dl_reg;
  logic signed [SAMPLE_BITS-1:0] fb_reg;
  logic signed [PW-1:0]          prod;

  // Combinational values.
  logic [DLW-1:0]                   d_ext;
  logic [DLW-1:0]                   d_cl;
  logic [DLW-1:0]                   wp_ext;
  logic [DLW-1:0]                   rd_full;
  logic [AW-1:0]                    rd_addr;
  logic signed [SAMPLE_BITS-1:0]    dl_eff;
  logic signed [GAIN_W:0]           gain_s;
  logic signed [SAMPLE_BITS-1:0]    mul_a;
  logic signed [SAMPLE_BITS+GAIN_W:0] mul_p;
  logic signed [PW-1:0]             rnd1;
  logic signed [PW-1:0]             rnd2;
  logic signed [PW-1:0]             fb_sum;
  logic signed [PW-1:0]             y_sum;
  logic signed [SAMPLE_BITS-1:0]    fb_sat;
  logic signed [SAMPLE_BITS-1:0]    y_sat;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      gain_q15      <= GAIN_RESET;
      delay_samples <= DELAY_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_GAIN:  gain_q15 <= cfg_wdata[GAIN_W-1:0];
        REG_DELAY: delay_samples <= cfg_wdata[DELAY_W-1:0];
        default:   ;
      endcase
    end
  end

  // Clamp the delay to one through the full depth, then find the read address.
  always_comb begin
    d_ext  = DLW'(delay_samples);
    wp_ext = DLW'(wp);
    if (d_ext == '0) begin
      d_cl = ONE_EXT;
    end else if (d_ext > MAX_EXT) begin
      d_cl = MAX_EXT;
    end else begin
      d_cl = d_ext;
    end
    if (wp_ext >= d_cl) begin
      rd_full = wp_ext - d_cl;
    end else begin
      rd_full = wp_ext + MAX_EXT - d_cl;
    end
    rd_addr = rd_full[AW-1:0];
  end

  // Delay line memory: write port for feedback, registered read port.
  always_ff @(posedge clk) begin
    if (cmd.do_fb) begin
      mem[wp] <= fb_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      rdata <= mem[rd_addr];
    end
  end

  // Entries not yet written since reset read as zero: everything below the
  // write pointer is written, and after the first wrap every entry is.
  always_ff @(posedge clk) begin
    if (rst) begin
      wp      <= '0;
      wrapped <= 1'b0;
      rd_ok   <= 1'b0;
    end else begin
      if (cmd.load_in) begin
        rd_ok <= wrapped || (rd_addr < wp);
      end
      if (cmd.do_fb) begin
        if (wp == WP_LAST) begin
          wp      <= '0;
          wrapped <= 1'b1;
        end else begin
          wp <= wp + AW'(1);
        end
      end
    end
  end

  assign dl_eff = rd_ok ? $signed(rdata) : '0;
  assign gain_s = $signed({1'b0, gain_q15});

  // Shared multiplier: delayed value first, then feedback value.
  assign mul_a = cmd.do_mul1 ? dl_eff : fb_reg;
  assign mul_p = mul_a * gain_s;

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      x_reg <= sample_in;
    end
    if (cmd.do_mul1) begin
      dl_reg <= dl_eff;
    end
    if (cmd.do_mul1 || cmd.do_mul2) begin
      prod <= PW'(mul_p);
    end
    if (cmd.do_fb) begin
      fb_reg <= fb_sat;
    end
    if (cmd.load_out) begin
      sample_out <= y_sat;
    end
  end

  // Round half up to Q.15 and saturate the feedback sum.
  always_comb begin
    rnd1   = (prod + HALF_LSB) >>> 15;
    fb_sum = PW'(x_reg) + rnd1;
    if (fb_sum > S_MAX) begin
      fb_sat = S_MAX[SAMPLE_BITS-1:0];
    end else if (fb_sum < S_MIN) begin
      fb_sat = S_MIN[SAMPLE_BITS-1:0];
    end else begin
      fb_sat = fb_sum[SAMPLE_BITS-1:0];
    end
  end

  // Negated, rounded product plus the delayed value, saturated.
  always_comb begin
    rnd2  = (HALF_LSB - prod) >>> 15;
    y_sum = rnd2 + PW'(dl_reg);
    if (y_sum > S_MAX) begin
      y_sat = S_MAX[SAMPLE_BITS-1:0];
    end else if (y_sum < S_MIN) begin
      y_sat = S_MIN[SAMPLE_BITS-1:0];
    end else begin
      y_sat = y_sum[SAMPLE_BITS-1:0];
    end
  end

endmodule

[src/schroeder_allpass_filter_core.sv]
// An accepted word passes the first multiply, feedback and second multiply steps, then
// enters the output register once it is free; the next word is not accepted before then.
// The delay line read, the multiplier used twice in a row and the feedback write set this.
// Reset: gain and delay return to their defaults and the write pointer to zero;
// unwritten delay entries read as zero through a wrap flag, so no clearing pass.
`timescale 1ns / 1ps

module schroeder_allpass_filter_core #(
  parameter int MAX_DELAY   = apf_pkg::MAX_DELAY_DEF,
  parameter int SAMPLE_BITS = apf_pkg::SAMPLE_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [apf_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [apf_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  apf_sample_if.sink                      sample_in,
  apf_sample_if.source                    sample_out
);
  import apf_pkg::*;

  apf_cmd_t cmd;

  // Sequencing.
  apf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sample_in.valid),
    .in_ready  (sample_in.ready),
    .out_ready (sample_out.ready),
    .out_valid (sample_out.valid),
    .cmd       (cmd)
  );

  // Arithmetic and storage.
  apf_datapath #(
    .MAX_DELAY   (MAX_DELAY),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .sample_in  (sample_in.data),
    .sample_out (sample_out.data)
  );

  // A new word never reaches the output register until the multiply and feedback steps are done.
  a_min_latency: assert property (@(posedge clk) disable iff (rst)
    cmd.load_in |=> !cmd.load_out ##1 !cmd.load_out ##1 !cmd.load_out)
    else $error("output loaded too early after accepting a word");

  // Feedback is formed only right after the first multiply.
  a_fb_order: assert property (@(posedge clk) disable iff (rst)
    cmd.do_fb |-> $past(cmd.do_mul1))
    else $error("feedback step without a preceding multiply");

  // The output register is never overwritten while holding an untaken word.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (sample_out.ready || !sample_out.valid))
    else $error("output word overwritten before it was taken");

  // Only one datapath step is commanded per cycle, apart from a new word entering.
  a_one_step: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.do_mul1, cmd.do_fb, cmd.do_mul2, cmd.load_out}))
    else $error("conflicting datapath commands");

endmodule
